// ===== src/rar_pkg.sv =====
// Shared constants and types for the rational arithmetic reduce core.
// No dependencies.
package rar_pkg;
  localparam int OPERAND_BITS_DEF = 16;
  localparam int FIELD_BITS = 16;
  localparam int NUM_BITS = 33;
  localparam int DEN_BITS = 32;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_NEG = 3'd4;

  // Shared unit operations
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } rar_ctl_t;
endpackage

// ===== src/rar_alu.sv =====
// Shared iterative unit: shift-add multiply and restoring divide, one bit a cycle.
// Depends on rar_pkg.
module rar_alu import rar_pkg::*; #(
  parameter int W = 2 * OPERAND_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  rar_ctl_t     ctl,
  input  logic [W-1:0] opa,
  input  logic [W-1:0] opb,
  output logic         done,
  output logic [W-1:0] res_q,
  output logic [W-1:0] res_r
);
  localparam int CW = $clog2(W + 1);

  logic         busy_r, busy_nxt;
  logic [1:0]   op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0] acc_r, acc_nxt;   // product or remainder
  logic [W-1:0] sh_r, sh_nxt;     // multiplier bits or quotient
  logic [W-1:0] b_r, b_nxt;
  logic         done_r, done_nxt;
  logic [W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    b_nxt    = b_r;
    done_nxt = 1'b0;
    trial    = {acc_r, sh_r[W-1]} - {1'b0, b_r};
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      cnt_nxt  = CW'(W);
      acc_nxt  = '0;
      sh_nxt   = opa;
      b_nxt    = opb;
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        // scan multiplier from the top bit
        acc_nxt = {acc_r[W-2:0], 1'b0} + (sh_r[W-1] ? b_r : '0);
        sh_nxt  = {sh_r[W-2:0], 1'b0};
      end else begin
        if (!trial[W]) begin
          acc_nxt = trial[W-1:0];
          sh_nxt  = {sh_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[W-2:0], sh_r[W-1]};
          sh_nxt  = {sh_r[W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    b_r   <= b_nxt;
  end

  assign done  = done_r;
  assign res_q = (op_r == OP_MUL) ? acc_r : sh_r;
  assign res_r = acc_r;
endmodule

// ===== src/rational_arith_reduce_core.sv =====
// Rational arithmetic with Euclid GCD reduction: one item at a time.
// Work: 0..3 multiplies, the GCD remainders and two divides, each on the shared shift-add/subtract
// unit; a zero-denominator request gets its error result registered straight on acceptance.
// A new request waits until the last is done: in_tready is high only when idle with the output empty.
// Reset (synchronous, rst_n low) returns the sequencer to idle and empties the output.
module rational_arith_reduce_core import rar_pkg::*; #(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // a_num, a_den, b_num, b_den (16 bits each)
  input  logic [2:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // res_num (33), res_den (32), zeros
  output logic        out_tuser   // zero_den_error
);
  localparam int OB = OPERAND_BITS;
  localparam int W  = 2 * OB + 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_M1 = 4'd1, S_M2 = 4'd2, S_M3 = 4'd3,
                         S_COMB = 4'd4, S_GCD = 4'd5, S_DN = 4'd6, S_DD = 4'd7,
                         S_OUT = 4'd8, S_WAITN = 4'd9;

  logic [3:0]   st_r, st_nxt;
  logic [2:0]   cmd_r, cmd_nxt;
  logic         ans_r, ans_nxt, ads_r, ads_nxt, bns_r, bns_nxt, bds_r, bds_nxt;
  logic [OB-1:0] anm_r, anm_nxt, adm_r, adm_nxt, bnm_r, bnm_nxt, bdm_r, bdm_nxt;
  logic [W-1:0] p_r, p_nxt, q_r, q_nxt, t_r, t_nxt;   // magnitudes / scratch
  logic         nneg_r, nneg_nxt, dneg_r, dneg_nxt, tneg_r, tneg_nxt;
  logic [W-1:0] nm_r, nm_nxt, dm_r, dm_nxt;
  logic         ov_r, ov_nxt, err_r, err_nxt, pend_r, pend_nxt;
  logic [NUM_BITS-1:0] on_r, on_nxt;
  logic [DEN_BITS-1:0] od_r, od_nxt;
  rar_ctl_t     ctl;
  logic [W-1:0] opa, opb, aq, ar;
  logic         adone;

  logic [OB-1:0] f_an, f_ad, f_bn, f_bd;
  assign f_an = in_tdata[OB-1:0];
  assign f_ad = in_tdata[FIELD_BITS+OB-1:FIELD_BITS];
  assign f_bn = in_tdata[2*FIELD_BITS+OB-1:2*FIELD_BITS];
  assign f_bd = in_tdata[3*FIELD_BITS+OB-1:3*FIELD_BITS];

  function automatic logic [OB-1:0] magof(input logic [OB-1:0] v);
    magof = v[OB-1] ? (~v + OB'(1)) : v;
  endfunction

  rar_alu #(.W(W)) u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .opa(opa), .opb(opb),
    .done(adone), .res_q(aq), .res_r(ar)
  );

  assign in_tready  = (st_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tuser  = err_r;
  assign out_tdata  = {7'd0, od_r, on_r};

  always_comb begin
    logic binary, bad;
    logic [W-1:0] ext_a, ext_b;
    binary = 1'b0;
    bad    = 1'b0;
    ext_a  = '0;
    ext_b  = '0;
    st_nxt = st_r;  cmd_nxt = cmd_r;
    ans_nxt = ans_r; ads_nxt = ads_r; bns_nxt = bns_r; bds_nxt = bds_r;
    anm_nxt = anm_r; adm_nxt = adm_r; bnm_nxt = bnm_r; bdm_nxt = bdm_r;
    p_nxt = p_r; q_nxt = q_r; t_nxt = t_r;
    nneg_nxt = nneg_r; dneg_nxt = dneg_r; tneg_nxt = tneg_r;
    nm_nxt = nm_r; dm_nxt = dm_r;
    ov_nxt = ov_r; err_nxt = err_r; pend_nxt = pend_r;
    on_nxt = on_r; od_nxt = od_r;
    ctl = '0;
    opa = '0;
    opb = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd_nxt = in_tuser;
          ans_nxt = f_an[OB-1]; ads_nxt = f_ad[OB-1];
          bns_nxt = f_bn[OB-1]; bds_nxt = f_bd[OB-1];
          anm_nxt = magof(f_an); adm_nxt = magof(f_ad);
          bnm_nxt = magof(f_bn); bdm_nxt = magof(f_bd);
          binary = (in_tuser <= CMD_DIV);
          bad = (f_ad == '0) || (binary && f_bd == '0) ||
                (in_tuser == CMD_DIV && f_bn == '0);
          if (bad) begin
            on_nxt = '0; od_nxt = DEN_BITS'(1); err_nxt = 1'b1; ov_nxt = 1'b1;
          end else if (binary) begin
            st_nxt = S_M1;
            pend_nxt = 1'b0;
          end else begin
            // unary: raw result is a itself, possibly negated
            nneg_nxt = (in_tuser == CMD_NEG) ? !f_an[OB-1] : f_an[OB-1];
            dneg_nxt = f_ad[OB-1];
            nm_nxt = W'(magof(f_an)); dm_nxt = W'(magof(f_ad));
            p_nxt = W'(magof(f_an)); q_nxt = W'(magof(f_ad));
            st_nxt = S_GCD;
            pend_nxt = 1'b0;
          end
        end
      end
      // M1: den = ad*bd (or bn*ad for divide)
      S_M1: begin
        ext_a = W'(adm_r);
        ext_b = (cmd_r == CMD_DIV) ? W'(bnm_r) : W'(bdm_r);
        opa = ext_a; opb = ext_b;
        if (!pend_r) begin
          ctl.start = 1'b1; ctl.op = OP_MUL; pend_nxt = 1'b1;
        end else if (adone) begin
          dm_nxt = aq;
          dneg_nxt = ads_r ^ ((cmd_r == CMD_DIV) ? bns_r : bds_r);
          pend_nxt = 1'b0; st_nxt = S_M2;
        end
      end
      // M2: an*bd (an*bn for multiply)
      S_M2: begin
        opa = W'(anm_r);
        opb = (cmd_r == CMD_MUL) ? W'(bnm_r) : W'(bdm_r);
        if (!pend_r) begin
          ctl.start = 1'b1; ctl.op = OP_MUL; pend_nxt = 1'b1;
        end else if (adone) begin
          nm_nxt = aq;
          nneg_nxt = ans_r ^ ((cmd_r == CMD_MUL) ? bns_r : bds_r);
          pend_nxt = 1'b0;
          st_nxt = (cmd_r == CMD_ADD || cmd_r == CMD_SUB) ? S_M3 : S_COMB;
        end
      end
      // M3: bn*ad for add and subtract
      S_M3: begin
        opa = W'(bnm_r); opb = W'(adm_r);
        if (!pend_r) begin
          ctl.start = 1'b1; ctl.op = OP_MUL; pend_nxt = 1'b1;
        end else if (adone) begin
          t_nxt = aq;
          tneg_nxt = bns_r ^ ads_r ^ (cmd_r == CMD_SUB);
          pend_nxt = 1'b0; st_nxt = S_COMB;
        end
      end
      S_COMB: begin
        if (cmd_r == CMD_ADD || cmd_r == CMD_SUB) begin
          if (nneg_r == tneg_r) begin
            nm_nxt = nm_r + t_r;
          end else if (nm_r >= t_r) begin
            nm_nxt = nm_r - t_r;
          end else begin
            nm_nxt = t_r - nm_r; nneg_nxt = tneg_r;
          end
          p_nxt = nm_nxt;
        end else begin
          p_nxt = nm_r;
        end
        q_nxt = dm_r;
        st_nxt = S_GCD;
      end
      // Euclid: p, q <- q, p mod q
      S_GCD: begin
        opa = p_r; opb = q_r;
        if (q_r == '0) begin
          if (p_r == '0) p_nxt = W'(1);
          st_nxt = S_DN;
        end else if (!pend_r) begin
          ctl.start = 1'b1; ctl.op = OP_DIV; pend_nxt = 1'b1;
        end else if (adone) begin
          p_nxt = q_r; q_nxt = ar; pend_nxt = 1'b0;
        end
      end
      S_DN: begin
        opa = nm_r; opb = p_r;
        if (!pend_r) begin
          ctl.start = 1'b1; ctl.op = OP_DIV; pend_nxt = 1'b1;
        end else if (adone) begin
          nm_nxt = aq; pend_nxt = 1'b0; st_nxt = S_DD;
        end
      end
      S_DD: begin
        opa = dm_r; opb = p_r;
        if (!pend_r) begin
          ctl.start = 1'b1; ctl.op = OP_DIV; pend_nxt = 1'b1;
        end else if (adone) begin
          dm_nxt = aq; pend_nxt = 1'b0; st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        on_nxt = NUM_BITS'(nneg_r ? (~{1'b0, nm_r} + 1'b1) : {1'b0, nm_r});
        od_nxt = DEN_BITS'(dneg_r ? (~{1'b0, dm_r} + 1'b1) : {1'b0, dm_r});
        err_nxt = 1'b0; ov_nxt = 1'b1;
        st_nxt = S_WAITN;
      end
      S_WAITN: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; pend_r <= pend_nxt;
    end
    cmd_r <= cmd_nxt;
    ans_r <= ans_nxt; ads_r <= ads_nxt; bns_r <= bns_nxt; bds_r <= bds_nxt;
    anm_r <= anm_nxt; adm_r <= adm_nxt; bnm_r <= bnm_nxt; bdm_r <= bdm_nxt;
    p_r <= p_nxt; q_r <= q_nxt; t_r <= t_nxt;
    nneg_r <= nneg_nxt; dneg_r <= dneg_nxt; tneg_r <= tneg_nxt;
    nm_r <= nm_nxt; dm_r <= dm_nxt;
    err_r <= err_nxt; on_r <= on_nxt; od_r <= od_nxt;
  end

  // A new request is never taken while a result is still waiting.
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !in_tready) else $error("request accepted with output full");
  // The shared unit only reports completion while a job is pending.
  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    adone |-> pend_r) else $error("unit done without pending job");
  // An error result is always 0/1.
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && err_r) |-> (on_r == '0 && od_r == DEN_BITS'(1)))
    else $error("bad error result");
  // Output register holds while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> (ov_r && $stable(on_r) && $stable(od_r)))
    else $error("output changed while stalled");
endmodule

// ===== tb/tb_rational_arith_reduce_core.sv =====
// Self-checking testbench for rational_arith_reduce_core: fraction add, subtract,
// multiply, divide, negate and reduce, checked against an exact in-bench predictor.
// Depends on rar_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_rational_arith_reduce_core;
  import rar_pkg::*;

  localparam int NUM_ITEMS = 1950;
  localparam logic [2:0] CMD_RED = 3'd5;

  typedef struct {
    logic [NUM_BITS-1:0] num;
    logic [DEN_BITS-1:0] den;
    logic                err;
  } frac_res_t;

  int err_count = 0;

  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    $display("MISMATCH %s: got %0d expected %0d", what, got, exp_v);
    err_count++;
  endtask

  class frac_scoreboard;
    frac_res_t pending[$];
    int n_in, n_out, n_err;

    static function longint unsigned euclid(longint unsigned p, longint unsigned q);
      longint unsigned t;
      while (q != 0) begin
        t = p % q;
        p = q;
        q = t;
      end
      return p;
    endfunction

    // Predict the reduced fraction; values are exact in 64-bit signed arithmetic
    function frac_res_t predict(logic [2:0] cmd, logic [15:0] an, logic [15:0] ad,
                                logic [15:0] bn, logic [15:0] bd);
      frac_res_t r;
      longint sa_n, sa_d, sb_n, sb_d, rn, rd;
      longint unsigned mn, md, g;
      bit binary;
      sa_n = longint'($signed(an));
      sa_d = longint'($signed(ad));
      sb_n = longint'($signed(bn));
      sb_d = longint'($signed(bd));
      binary = (cmd <= CMD_DIV);
      if (sa_d == 0 || (binary && sb_d == 0) || (cmd == CMD_DIV && sb_n == 0)) begin
        r.num = '0;
        r.den = DEN_BITS'(1);
        r.err = 1'b1;
        return r;
      end
      case (cmd)
        CMD_ADD: begin rn = sa_n * sb_d + sb_n * sa_d; rd = sa_d * sb_d; end
        CMD_SUB: begin rn = sa_n * sb_d - sb_n * sa_d; rd = sa_d * sb_d; end
        CMD_MUL: begin rn = sa_n * sb_n; rd = sa_d * sb_d; end
        CMD_DIV: begin rn = sa_n * sb_d; rd = sb_n * sa_d; end
        CMD_NEG: begin rn = -sa_n; rd = sa_d; end
        default: begin rn = sa_n; rd = sa_d; end
      endcase
      mn = (rn < 0) ? -rn : rn;
      md = (rd < 0) ? -rd : rd;
      g = euclid(mn, md);
      if (g == 0) g = 1;
      rn = rn / longint'(g);
      rd = rd / longint'(g);
      r.num = rn[NUM_BITS-1:0];
      r.den = rd[DEN_BITS-1:0];
      r.err = 1'b0;
      return r;
    endfunction

    function void note_request(logic [2:0] cmd, logic [63:0] d);
      pending.push_back(predict(cmd, d[15:0], d[31:16], d[47:32], d[63:48]));
      n_in++;
    endfunction

    task check_result(logic [71:0] d, logic u);
      frac_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", d[NUM_BITS-1:0], 0);
        return;
      end
      e = pending.pop_front();
      n_out++;
      if (e.err) n_err++;
      if (d[NUM_BITS-1:0] !== e.num)
        report_mismatch("res_num", $signed(d[NUM_BITS-1:0]), $signed(e.num));
      if (d[NUM_BITS+DEN_BITS-1:NUM_BITS] !== e.den)
        report_mismatch("res_den", $signed(d[NUM_BITS+DEN_BITS-1:NUM_BITS]),
                        $signed(e.den));
      if (d[71:NUM_BITS+DEN_BITS] !== '0)
        report_mismatch("pad bits", d[71:NUM_BITS+DEN_BITS], 0);
      if (u !== e.err) report_mismatch("zero_den_error", u, e.err);
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;
  logic        out_tuser;

  frac_scoreboard sb = new();
  bit hold_off = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rational_arith_reduce_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Send one request and wait for its acceptance, then idle a drawn number of cycles when gaps is set
  task automatic send_request(input logic [2:0] cmd, input logic [15:0] an,
                              input logic [15:0] ad, input logic [15:0] bn,
                              input logic [15:0] bd, input bit gaps);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {bd, bn, ad, an};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(cmd, {bd, bn, ad, an});
    gap = gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Operand with a bias towards small and extreme values
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 4)) - 2);
      3, 4, 5: return 16'(int'($urandom_range(0, 60)) - 30);
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: random stalls per item, plus a long hold-off when asked
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata, out_tuser);
    end
  end

  initial begin
    logic [15:0] dir_vals[6];
    logic [2:0] cmd;
    logic [15:0] f[4];
    int wait_cyc;
    dir_vals = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'h0001, 16'h0006};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every command, extremes, zero numerators and zero denominators
    send_request(CMD_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h8001, 0);
    send_request(CMD_SUB, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 0);
    send_request(CMD_MUL, 16'h8000, 16'h0001, 16'h8000, 16'h0001, 0);
    send_request(CMD_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 0);
    send_request(CMD_NEG, 16'h8000, 16'hffff, 16'h0000, 16'h0000, 0);
    send_request(CMD_RED, 16'h0006, 16'hfffc, 16'h1234, 16'h0000, 0);
    send_request(3'd6, 16'h000c, 16'h0012, 16'h0000, 16'h0000, 0);
    send_request(3'd7, 16'hfff4, 16'hfff7, 16'h0001, 16'h0000, 0);
    send_request(CMD_ADD, 16'h0001, 16'h0002, 16'hffff, 16'h0002, 0);
    send_request(CMD_SUB, 16'h0003, 16'hfffd, 16'h0001, 16'h0001, 0);
    send_request(CMD_MUL, 16'h0000, 16'hfffb, 16'h0007, 16'h0003, 0);
    send_request(CMD_ADD, 16'h0001, 16'h0000, 16'h0001, 16'h0001, 0);
    send_request(CMD_ADD, 16'h0001, 16'h0001, 16'h0001, 16'h0000, 0);
    send_request(CMD_DIV, 16'h0001, 16'h0002, 16'h0000, 16'h0003, 0);
    send_request(CMD_NEG, 16'h0001, 16'h0000, 16'h0001, 16'h0001, 0);
    send_request(CMD_RED, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 0);
    send_request(CMD_NEG, 16'h0005, 16'h0003, 16'h0001, 16'h0000, 0);
    send_request(CMD_DIV, 16'h0000, 16'h0004, 16'h0002, 16'hfff8, 0);
    send_request(CMD_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);
    send_request(CMD_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);

    // Long receiver hold-off while requests keep coming
    hold_off = 1;
    for (int i = 0; i < 6; i++)
      send_request(3'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                   pick_operand(), pick_operand(), 0);

    for (int i = 0; i < NUM_ITEMS; i++) begin
      cmd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
      foreach (f[k]) f[k] = pick_operand();
      if (i % 40 < 3) foreach (f[k]) f[k] = dir_vals[$urandom_range(0, 5)];
      // Keep zero-denominator errors occasional
      if (f[1] == 0 && $urandom_range(0, 3) != 0) f[1] = 16'h0001;
      if (f[3] == 0 && $urandom_range(0, 3) != 0) f[3] = 16'hffff;
      send_request(cmd, f[0], f[1], f[2], f[3], i % 7 != 0);
      // Sender pause until the pipeline drains
      if (i == NUM_ITEMS / 2) begin
        in_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    wait_cyc = 0;
    while (sb.pending.size() != 0 && wait_cyc < 200000) begin
      @(posedge clk);
      wait_cyc++;
    end
    if (sb.pending.size() != 0) report_mismatch("results missing", sb.pending.size(), 0);
    repeat (1500) @(posedge clk);

    $display("Covered %0d requests over all commands, %0d results, %0d zero-denominator cases",
             sb.n_in, sb.n_out, sb.n_err);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Run timed out");
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== rational_arith_reduce_core.f =====
src/rar_pkg.sv
src/rar_alu.sv
src/rational_arith_reduce_core.sv
tb/tb_rational_arith_reduce_core.sv
